[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL; they compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SKT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SKT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SKT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SKT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SKT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SKT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/skt_pkg.sv]
`timescale 1ns / 1ps

package skt_pkg;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 40;
    localparam int VAL_W    = 16;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int ECNT_W   = 7;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [VAL_W-1:0]    value_out;
        logic [ECNT_W-1:0]   entry_count;
    } result_t;

endpackage

[hw/rtl/skt_req_if.sv]
`timescale 1ns / 1ps

interface skt_req_if import skt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value_in;

    modport source (output valid, output func, output key, output value_in, input ready);
    modport sink (input valid, input func, input key, input value_in, output ready);
endinterface

[hw/rtl/skt_rsp_if.sv]
`timescale 1ns / 1ps

interface skt_rsp_if import skt_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [VAL_W-1:0]    value_out;
    logic [ECNT_W-1:0]   entry_count;

    modport source (
        output valid, output status, output position, output value_out,
        output entry_count, input ready
    );
    modport sink (
        input valid, input status, input position, input value_out,
        input entry_count, output ready
    );
endinterface

[hw/rtl/skt_mem.sv]
`timescale 1ns / 1ps

module skt_mem import skt_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/skt_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skt_ctrl import skt_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  req_t             in_data,
    input  logic             out_free,
    output logic             done,
    output result_t          res,
    output logic             rd_en,
    output logic [IDX_W-1:0] rd_addr,
    input  entry_t           rd_data,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_addr,
    output entry_t           wr_data
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRD   = 7'b0000010,
        S_SCMP  = 7'b0000100,
        S_SHIFT = 7'b0001000,
        S_LAST  = 7'b0010000,
        S_PUT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                pend_reg, pend_next;
    logic [FUNC_W-1:0]   fn_reg, fn_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [IDX_W-1:0]    mid_reg, mid_next;
    logic [IDX_W-1:0]    p_reg, p_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [IDX_W-1:0]    dst_reg, dst_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [VAL_W-1:0]    vout_reg, vout_next;
    logic [CNT_W-1:0]    mid_sum;
    logic [IDX_W-1:0]    mid;
    logic                shift_last;

    assign mid_sum  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid      = IDX_W'(mid_sum);
    assign in_ready = (state_reg == S_IDLE);

    assign shift_last = (fn_reg == FN_INSERT) ? (ptr_reg == p_reg)
                                              : (ptr_reg == IDX_W'(count_reg - 1'b1));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pend_next   = pend_reg;
        fn_next     = fn_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        p_next      = p_reg;
        ptr_next    = ptr_reg;
        dst_next    = dst_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        vout_next   = vout_reg;
        rd_en       = 1'b0;
        rd_addr     = mid;
        wr_en       = 1'b0;
        wr_addr     = dst_reg;
        wr_data     = rd_data;
        done        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    fn_next     = in_data.func;
                    key_next    = in_data.key;
                    val_next    = in_data.value_in;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    status_next = ST_OK;
                    pos_next    = '0;
                    vout_next   = '0;
                    if (in_data.func inside {FN_INSERT, FN_LOOKUP, FN_DELETE})
                    begin
                        state_next = S_SRD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SRD:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    mid_next   = mid;
                    state_next = S_SCMP;
                end
                else if (fn_reg == FN_INSERT)
                begin
                    if (count_reg >= MAX_CNT)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        p_next   = IDX_W'(lo_reg);
                        pos_next = POS_W'(lo_reg);
                        if (count_reg > lo_reg)
                        begin
                            ptr_next   = IDX_W'(count_reg - 1'b1);
                            pend_next  = 1'b0;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end
                end
                else
                begin
                    status_next = ST_MISS;
                    state_next  = S_DONE;
                end
            end

            S_SCMP:
            begin
                if (rd_data.key == key_reg)
                begin
                    pos_next   = POS_W'(mid_reg);
                    state_next = S_DONE;
                    case (fn_reg)
                        FN_INSERT:
                        begin
                            status_next = ST_DUP;
                        end
                        FN_LOOKUP:
                        begin
                            vout_next = rd_data.value;
                        end
                        FN_DELETE:
                        begin
                            p_next = mid_reg;
                            if ((CNT_W'(mid_reg) + 1'b1) < count_reg)
                            begin
                                ptr_next   = mid_reg + 1'b1;
                                pend_next  = 1'b0;
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
                else if (rd_data.key > key_reg)
                begin
                    hi_next    = CNT_W'(mid_reg);
                    state_next = S_SRD;
                end
                else
                begin
                    lo_next    = CNT_W'(mid_reg) + 1'b1;
                    state_next = S_SRD;
                end
            end

            S_SHIFT:
            begin
                rd_en     = 1'b1;
                rd_addr   = ptr_reg;
                wr_en     = pend_reg;
                pend_next = 1'b1;
                dst_next  = (fn_reg == FN_INSERT) ? ptr_reg + 1'b1 : ptr_reg - 1'b1;
                if (shift_last)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    ptr_next = (fn_reg == FN_INSERT) ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                end
            end

            S_LAST:
            begin
                wr_en = 1'b1;
                if (fn_reg == FN_INSERT)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_PUT:
            begin
                wr_en         = 1'b1;
                wr_addr       = p_reg;
                wr_data.key   = key_reg;
                wr_data.value = val_reg;
                count_next    = count_reg + 1'b1;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fn_reg     <= fn_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        p_reg      <= p_next;
        ptr_reg    <= ptr_next;
        dst_reg    <= dst_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        vout_reg   <= vout_next;
    end

    assign res.status      = status_reg;
    assign res.position    = pos_reg;
    assign res.value_out   = vout_reg;
    assign res.entry_count = ECNT_W'(count_reg);

    `SKT_ASSERT(a_count_range, clk, rst_n, count_reg <= MAX_CNT, "entry count exceeds capacity")
    `SKT_ASSERT_IMP(a_no_rw_collide, clk, rst_n, rd_en && wr_en, rd_addr != wr_addr, "shift reads and writes the same entry")
    `SKT_ASSERT_IMP(a_search_bounds, clk, rst_n, state_reg == S_SRD, lo_reg <= hi_reg && hi_reg <= count_reg, "search range left the table")
    `SKT_ASSERT_NXT(a_idle_count_hold, clk, rst_n, state_reg == S_IDLE, $stable(count_reg), "entry count changed while idle")

endmodule

[hw/rtl/sorted_key_table.sv]
`timescale 1ns / 1ps

// Sorted table of up to MAX_ENTRIES 40-bit keys with 16-bit values, held in one
// single-port-read, single-port-write memory whose read data is registered. Each
// transaction on req is an insert, lookup or delete (other function codes are
// answered with ST_OK), and each yields exactly one transaction on rsp; one
// request is worked at a time. A binary search issues each probe's read in S_SRD
// and compares its key in S_SCMP. Insert then moves every entry at or above the
// insert position up, and delete every entry above the deleted one down, by one
// memory read and one memory write per cycle, pipelined so that each entry read is
// written back while the next is read; insert then writes the new entry in S_PUT.
// The memory needs no clearing after reset: only entries below the entry count are
// ever read. Results sit in an output register, so a new request is taken while
// the previous result waits on rsp.
module sorted_key_table import skt_pkg::*; #(
    parameter int MAX_ENTRIES = 64
) (
    input logic           clk,
    input logic           rst_n,
    skt_req_if.sink       req,
    skt_rsp_if.source     rsp
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    req_t             in_data;
    result_t          res;
    logic             done;
    logic             out_free;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    entry_t           rd_data;
    entry_t           wr_data;
    logic             out_valid_reg;
    result_t          out_reg;

    assign in_data.func     = req.func;
    assign in_data.key      = req.key;
    assign in_data.value_in = req.value_in;

    assign out_free = !out_valid_reg || rsp.ready;

    skt_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .in_data  (in_data),
        .out_free (out_free),
        .done     (done),
        .res      (res),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    skt_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.position    = out_reg.position;
    assign rsp.value_out   = out_reg.value_out;
    assign rsp.entry_count = out_reg.entry_count;

endmodule
